[sv/bdsl_pkg.sv]
`timescale 1ns / 1ps

package bdsl_pkg;

  // Storage geometry and field widths.
  localparam int DEPTH  = 16;
  localparam int VAL_W  = 32;
  localparam int REQ_W  = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_DEL_ALL    = 4'd6;
  localparam logic [REQ_W-1:0] REQ_INS_ASC    = 4'd7;
  localparam logic [REQ_W-1:0] REQ_INS_DESC   = 4'd8;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_TAIL
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

[sv/bdsl_ctrl.sv]
`timescale 1ns / 1ps

module bdsl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdsl_pkg::dp_stat_t stat,
  output bdsl_pkg::dp_cmd_t  cmd
);
  import bdsl_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_SCAN;
      end
      CS_SCAN: begin
        if (stat.scan_done) state_nxt = CS_TAIL;
      end
      CS_TAIL: begin
        if (out_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == CS_IDLE);
    cmd.start  = (state_r == CS_IDLE) && in_valid;
    cmd.scan   = (state_r == CS_SCAN);
    cmd.finish = (state_r == CS_TAIL) && out_free;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/bdsl_dp.sv]
`timescale 1ns / 1ps

module bdsl_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bdsl_pkg::REQ_W-1:0]    in_req_type,
  input  logic [bdsl_pkg::VAL_W-1:0]    in_operand_value,
  input  bdsl_pkg::dp_cmd_t             cmd,
  output bdsl_pkg::dp_stat_t            stat,
  output logic [bdsl_pkg::VAL_W-1:0]    out_popped_value,
  output logic                          out_found,
  output logic [bdsl_pkg::CNT_W-1:0]    out_match_position,
  output logic [bdsl_pkg::CNT_W-1:0]    out_removed_count,
  output logic [bdsl_pkg::CNT_W-1:0]    out_occupancy,
  output logic [bdsl_pkg::STAT_W-1:0]   out_status
);
  import bdsl_pkg::*;

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata_r;

  logic [CNT_W-1:0]  cnt_r;
  logic              pv_r;
  logic [REQ_W-1:0]  op_r;
  logic [VAL_W-1:0]  val_r;
  logic              quick_r;
  logic [STAT_W-1:0] qstat_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic [IDX_W-1:0]  pk_r;
  logic [CNT_W-1:0]  w_r;
  logic              found_r;
  logic [IDX_W-1:0]  pos_r;
  logic [VAL_W-1:0]  popped_r;
  logic              ins_r;
  logic [VAL_W-1:0]  hold_r;

  logic              start_quick;
  logic [STAT_W-1:0] start_qstat;
  logic              rd_en;
  logic              ins_mode, srch_mode, pop_mode, del_mode;
  logic              is_match, first, is_last;
  logic              ins_cond, here, shifting, drop, new_match;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [CNT_W-1:0]  new_cnt;

  // Requests that finish without touching the store.
  always_comb begin
    start_quick = 1'b0;
    start_qstat = ST_OK;
    case (in_req_type)
      REQ_PUSH_FRONT, REQ_PUSH_REAR, REQ_INS_ASC, REQ_INS_DESC: begin
        start_quick = (cnt_r == CNT_W'(DEPTH));
        start_qstat = ST_FULL;
      end
      REQ_POP_FRONT, REQ_POP_REAR: begin
        start_quick = (cnt_r == '0);
        start_qstat = ST_EMPTY;
      end
      REQ_SEARCH, REQ_DEL_FIRST, REQ_DEL_ALL: begin
        start_quick = 1'b0;
        start_qstat = ST_OK;
      end
      default: begin
        start_quick = 1'b1;
        start_qstat = ST_OK;
      end
    endcase
  end

  assign rd_en          = cmd.scan && !quick_r && (rd_idx_r < cnt_r);
  assign stat.scan_done = quick_r || ((rd_idx_r == cnt_r) && !pv_r);

  always_comb begin
    ins_mode  = op_r inside {REQ_PUSH_FRONT, REQ_PUSH_REAR, REQ_INS_ASC, REQ_INS_DESC};
    srch_mode = op_r inside {REQ_SEARCH, REQ_DEL_FIRST, REQ_DEL_ALL};
    pop_mode  = op_r inside {REQ_POP_FRONT, REQ_POP_REAR};
    del_mode  = op_r inside {REQ_DEL_FIRST, REQ_DEL_ALL};
    is_match  = (rdata_r == val_r);
    first     = (pk_r == '0);
    is_last   = (CNT_W'(pk_r) == cnt_r - CNT_W'(1));

    case (op_r)
      REQ_PUSH_FRONT: ins_cond = first;
      REQ_INS_ASC:    ins_cond = first ? (val_r < rdata_r) : (rdata_r >= val_r);
      REQ_INS_DESC:   ins_cond = first ? (val_r > rdata_r) : (rdata_r <= val_r);
      default:        ins_cond = 1'b0;
    endcase
    here     = pv_r && ins_mode && !ins_r && ins_cond;
    shifting = pv_r && ins_mode && (ins_r || here);

    case (op_r)
      REQ_POP_FRONT: drop = first;
      REQ_POP_REAR:  drop = is_last;
      REQ_DEL_FIRST: drop = is_match && !found_r;
      REQ_DEL_ALL:   drop = is_match;
      default:       drop = 1'b0;
    endcase
    new_match = pv_r && srch_mode && is_match && !found_r;

    // One write port: stream writes while scanning, the tail write on finish.
    wr_en   = 1'b0;
    wr_addr = pk_r;
    wr_data = rdata_r;
    if (shifting) begin
      wr_en   = 1'b1;
      wr_addr = pk_r;
      wr_data = here ? val_r : hold_r;
    end else if (pv_r && !ins_mode && !drop) begin
      wr_en   = 1'b1;
      wr_addr = w_r[IDX_W-1:0];
      wr_data = rdata_r;
    end else if (cmd.finish && !quick_r && ins_mode) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[IDX_W-1:0];
      wr_data = ins_r ? hold_r : val_r;
    end

    if (quick_r) begin
      new_cnt = cnt_r;
    end else if (ins_mode) begin
      new_cnt = cnt_r + CNT_W'(1);
    end else begin
      new_cnt = w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_idx_r[IDX_W-1:0]];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      pv_r <= rd_en;
      if (cmd.finish) cnt_r <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r     <= in_req_type;
      val_r    <= in_operand_value;
      quick_r  <= start_quick;
      qstat_r  <= start_qstat;
      rd_idx_r <= '0;
      w_r      <= '0;
      found_r  <= 1'b0;
      pos_r    <= '0;
      popped_r <= '0;
      ins_r    <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
        pk_r     <= rd_idx_r[IDX_W-1:0];
      end
      if (pv_r && !ins_mode && !drop) w_r <= w_r + CNT_W'(1);
      if (shifting) begin
        hold_r <= rdata_r;
        ins_r  <= 1'b1;
      end
      if (new_match) begin
        found_r <= 1'b1;
        pos_r   <= pk_r;
      end
      if (pv_r && pop_mode && drop) popped_r <= rdata_r;
    end

    if (cmd.finish) begin
      out_popped_value <= popped_r;
      out_found        <= found_r;
      out_occupancy    <= new_cnt;
      if (quick_r) begin
        out_status         <= qstat_r;
        out_match_position <= '0;
        out_removed_count  <= '0;
      end else if (srch_mode) begin
        out_status         <= found_r ? ST_OK : ST_NOT_FOUND;
        out_match_position <= found_r ? CNT_W'(pos_r) : cnt_r;
        out_removed_count  <= del_mode ? (cnt_r - w_r) : '0;
      end else begin
        out_status         <= ST_OK;
        out_match_position <= '0;
        out_removed_count  <= '0;
      end
    end
  end

endmodule

[sv/bounded_deque_sorted_list_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_req_type, in_operand_value
// out_      output     out_valid / out_ready   out_popped_value, out_found,
//                                              out_match_position, out_removed_count,
//                                              out_occupancy, out_status
//
// One item is worked at a time. A request that touches the store makes a single-pass
// walk over the held entries through the store's one registered read port; a request
// rejected at once (full, empty or unused code) skips the walk.
// Reset (rst_n low, synchronous) empties the list; the store contents are not cleared.
// A result that is not taken stalls only the final write-back step of the next item.

module bounded_deque_sorted_list_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bdsl_pkg::REQ_W-1:0]    in_req_type,
  input  logic [bdsl_pkg::VAL_W-1:0]    in_operand_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bdsl_pkg::VAL_W-1:0]    out_popped_value,
  output logic                          out_found,
  output logic [bdsl_pkg::CNT_W-1:0]    out_match_position,
  output logic [bdsl_pkg::CNT_W-1:0]    out_removed_count,
  output logic [bdsl_pkg::CNT_W-1:0]    out_occupancy,
  output logic [bdsl_pkg::STAT_W-1:0]   out_status
);
  import bdsl_pkg::*;

  // The controller steps through accept, scan and tail. The datapath owns the store
  // and carries out each request that reaches the store as one forward pass over the
  // held entries: removals compact the list behind a write pointer, while insertions
  // ripple entries from the insertion point one place rearward via a holding register.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The result registers live in the datapath and are loaded only when the
  // previous item has been taken, so a result holds steady while stalled.
  bdsl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_operand_value   (in_operand_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_popped_value   (out_popped_value),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .out_removed_count  (out_removed_count),
    .out_occupancy      (out_occupancy),
    .out_status         (out_status)
  );

endmodule

[sv/bdsl_checker.sv]
`timescale 1ns / 1ps

module bdsl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bdsl_pkg::VAL_W-1:0]    out_popped_value,
  input logic                          out_found,
  input logic [bdsl_pkg::CNT_W-1:0]    out_match_position,
  input logic [bdsl_pkg::CNT_W-1:0]    out_removed_count,
  input logic [bdsl_pkg::CNT_W-1:0]    out_occupancy,
  input logic [bdsl_pkg::STAT_W-1:0]   out_status
);
  import bdsl_pkg::*;

  // A stalled result stays valid and keeps its occupancy, status, popped value and match position.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_occupancy) && $stable(out_status)
      && $stable(out_popped_value) && $stable(out_match_position))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == CNT_W'(DEPTH))
    else $error("full status with free room");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0 && out_popped_value == '0)
    else $error("empty status on a non-empty list");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |->
      !out_found && out_removed_count == '0 && out_match_position == out_occupancy)
    else $error("inconsistent miss result");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= CNT_W'(DEPTH)
      && CNT_W'(out_occupancy + out_removed_count) <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

endmodule

bind bounded_deque_sorted_list_unit bdsl_checker u_bdsl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_popped_value   (out_popped_value),
  .out_found          (out_found),
  .out_match_position (out_match_position),
  .out_removed_count  (out_removed_count),
  .out_occupancy      (out_occupancy),
  .out_status         (out_status)
);
